@@ rtl/six_axis_deadzone_reporter_core_defines.svh @@
// Assertion macros for the six-axis dead-zone reporter checker.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef SIX_AXIS_DEADZONE_REPORTER_CORE_DEFINES_SVH
`define SIX_AXIS_DEADZONE_REPORTER_CORE_DEFINES_SVH

// clocked assertion, off during reset
`define SDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/sdr_pkg.sv @@
// Shared types and constants of the six-axis dead-zone reporter.
// No dependencies.
package sdr_pkg;

  localparam int VEC_W  = 19;
  localparam int CFG_W  = 10;
  localparam int CODE_W = 10;
  localparam int RAW_W  = 16;
  localparam int ACT_W  = 3;
  localparam int MAG_W  = 10;
  localparam int T_W    = 25;  // 100 * |component|
  localparam int ACC_W  = 52;  // sum of three squares of T_W
  localparam int ROOT_W = 26;
  localparam int REM_W  = 29;

  localparam int VEC_MAX = 262143;
  localparam int VEC_MIN = -262144;
  localparam int MAG_MAX = 1023;
  localparam int MAG_SCALE = 100;
  localparam int BUTTON_MAG = 100;

  typedef logic signed [VEC_W-1:0] vec_t;

  typedef enum logic [1:0] {
    KIND_SYNC = 2'd0,
    KIND_REL  = 2'd1,
    KIND_KEY  = 2'd2,
    KIND_MISC = 2'd3
  } kind_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_MOVE   = 3'd3,
    ACT_ROTATE = 3'd4,
    ACT_BUTTON = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    AX_X  = 3'd0,
    AX_Y  = 3'd1,
    AX_Z  = 3'd2,
    AX_RX = 3'd3,
    AX_RY = 3'd4,
    AX_RZ = 3'd5
  } axis_e;

  localparam logic [CODE_W-1:0] KEY_BUTTON0 = 10'd256;

  typedef enum logic {
    CFG_DEADZONE   = 1'b0,
    CFG_FULL_SCALE = 1'b1
  } cfg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_APPLY = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  // saturate a one-bit-wider signed sum into the vector range
  function automatic vec_t sat_vec(input logic signed [VEC_W:0] v);
    vec_t r;
    if (v[VEC_W] != v[VEC_W-1]) r = v[VEC_W] ? vec_t'(VEC_MIN) : vec_t'(VEC_MAX);
    else r = v[VEC_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/sdr_if.sv @@
// Handshake channels for events in and reports out.
// Depends on sdr_pkg.
interface sdr_evt_if import sdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [CODE_W-1:0] code;
  logic signed [RAW_W-1:0] axis_value;
  logic              link_up;
  modport source (output valid, kind, code, axis_value, link_up, input ready);
  modport sink   (input valid, kind, code, axis_value, link_up, output ready);
endinterface

interface sdr_res_if import sdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  vec_t             vec_x;
  vec_t             vec_y;
  vec_t             vec_z;
  logic [MAG_W-1:0] magnitude;
  logic             last;
  modport source (output valid, action, vec_x, vec_y, vec_z, magnitude, last, input ready);
  modport sink   (input valid, action, vec_x, vec_y, vec_z, magnitude, last, output ready);
endinterface

@@ rtl/six_axis_deadzone_reporter_core.sv @@
// Six-axis dead-zone reporter: one event at a time through a shared sequencer.
// Axis event: 10+FRAC_BITS divider steps, then the apply step (no divide if full_scale <= deadzone).
// Report: per result a load, the multiplier passes over three components, 26 root steps, then hand-off.
// Key: button 0 goes straight to the output register. Ready only while idle.
// Reset (async, active low): deadzone 20, full_scale 350, vectors and flags zero.
module six_axis_deadzone_reporter_core
  import sdr_pkg::*;
#(
  parameter int FRAC_BITS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  sdr_evt_if.sink          evt_i,
  sdr_res_if.source        res_o
);

  localparam int NW  = CFG_W + FRAC_BITS;
  localparam int CW  = (NW > VEC_W + 1) ? NW : VEC_W + 1;
  localparam int DCW = $clog2(NW);
  localparam int SCW = $clog2(ROOT_W);

  state_e state_q, state_d;

  logic [CFG_W-1:0] dz_q, fs_q;
  vec_t mx_q, my_q, mz_q, rx_q, ry_q, rz_q;
  logic mv_pend_q, rot_pend_q;

  logic [2:0]       axis_q;
  logic             neg_q;
  logic [NW-1:0]    num_q;
  logic [CFG_W:0]   rem_q;
  logic [CFG_W-1:0] dvs_q;
  logic [DCW-1:0]   dcnt_q;

  logic       mv_todo_q, rot_todo_q;
  logic [1:0] rot_idx_q;
  vec_t       cx_q, cy_q, cz_q;
  logic [ACT_W-1:0] act_q;
  logic       last_q;
  logic [MAG_W-1:0] mag_q;

  logic [1:0]       comp_q, ph_q;
  logic [T_W-1:0]   t_q;
  logic [2*T_W-1:0] sq_q;
  logic [ACC_W-1:0] acc_q, rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  srem_q;
  logic [SCW-1:0]    scnt_q;

  // datapath helpers
  logic [CFG_W:0]  rem_sh;
  logic            dbit;
  logic [15:0]     amag;
  logic [CFG_W-1:0] lim;
  logic            in_dz;
  logic [CW-1:0]   q_ext;
  vec_t            s_v;
  logic signed [VEC_W:0] sum_x, dif_y, dif_z;
  vec_t            csel;
  logic [VEC_W-1:0] cabs;
  logic [T_W-1:0]  mul_a, mul_b;
  logic [2*T_W-1:0] prod;
  logic [ACC_W-1:0] acc_n;
  logic [REM_W-1:0] srem_sh, trial;
  logic [ROOT_W-1:0] root_n, root_mag;
  logic [REM_W-1:0]  srem_n;

  assign evt_i.ready     = (state_q == S_IDLE);
  assign res_o.valid     = (state_q == S_OUT);
  assign res_o.action    = act_q;
  assign res_o.vec_x     = cx_q;
  assign res_o.vec_y     = cy_q;
  assign res_o.vec_z     = cz_q;
  assign res_o.magnitude = mag_q;
  assign res_o.last      = last_q;

  always_comb begin
    amag = evt_i.axis_value[RAW_W-1] ? 16'(-evt_i.axis_value) : 16'(evt_i.axis_value);
    in_dz = (amag <= 16'(dz_q));
    lim = (amag > 16'(fs_q)) ? fs_q : amag[CFG_W-1:0];

    rem_sh = {rem_q[CFG_W-1:0], num_q[NW-1]};
    dbit   = (rem_sh >= {1'b0, dvs_q});

    q_ext = CW'(num_q);
    if (neg_q) begin
      s_v = (q_ext >= CW'(-VEC_MIN)) ? vec_t'(VEC_MIN) : -vec_t'(q_ext[VEC_W-1:0]);
    end else begin
      s_v = (q_ext > CW'(VEC_MAX)) ? vec_t'(VEC_MAX) : vec_t'(q_ext[VEC_W-1:0]);
    end
    sum_x = {mx_q[VEC_W-1], mx_q} + {s_v[VEC_W-1], s_v};
    dif_y = {my_q[VEC_W-1], my_q} - {s_v[VEC_W-1], s_v};
    dif_z = {mz_q[VEC_W-1], mz_q} - {s_v[VEC_W-1], s_v};

    case (comp_q)
      2'd0:    csel = cx_q;
      2'd1:    csel = cy_q;
      default: csel = cz_q;
    endcase
    cabs = csel[VEC_W-1] ? VEC_W'(-csel) : VEC_W'(csel);
    // shared multiplier: first 100*|c|, then its square
    mul_a = (ph_q == 2'd0) ? T_W'(cabs) : t_q;
    mul_b = (ph_q == 2'd0) ? T_W'(MAG_SCALE) : t_q;
    prod  = mul_a * mul_b;
    acc_n = acc_q + ACC_W'(sq_q);

    srem_sh = {srem_q[REM_W-3:0], rad_q[ACC_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    if (srem_sh >= trial) begin
      srem_n = srem_sh - trial;
      root_n = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      srem_n = srem_sh;
      root_n = {root_q[ROOT_W-2:0], 1'b0};
    end
    root_mag = root_n >> FRAC_BITS;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (evt_i.valid && evt_i.link_up) begin
          case (evt_i.kind)
            KIND_SYNC: if (mv_pend_q || rot_pend_q) state_d = S_LOAD;
            KIND_REL:  if (!in_dz && evt_i.code <= CODE_W'(AX_RZ)) begin
              state_d = (fs_q > dz_q) ? S_DIV : S_APPLY;
            end
            KIND_KEY:  if (evt_i.code == KEY_BUTTON0) state_d = S_OUT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_DIV:   if (dcnt_q == DCW'(NW - 1)) state_d = S_APPLY;
      S_APPLY: state_d = S_IDLE;
      S_LOAD:  state_d = S_MUL;
      S_MUL:   if (ph_q == 2'd2 && comp_q == 2'd2) state_d = S_SQRT;
      S_SQRT:  if (scnt_q == SCW'(ROOT_W - 1)) state_d = S_OUT;
      S_OUT:   if (res_o.ready) state_d = (mv_todo_q || rot_todo_q) ? S_LOAD : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dz_q       <= CFG_W'(20);
      fs_q       <= CFG_W'(350);
      mx_q       <= '0;
      my_q       <= '0;
      mz_q       <= '0;
      rx_q       <= '0;
      ry_q       <= '0;
      rz_q       <= '0;
      mv_pend_q  <= 1'b0;
      rot_pend_q <= 1'b0;
      mv_todo_q  <= 1'b0;
      rot_todo_q <= 1'b0;
      rot_idx_q  <= '0;
      dcnt_q     <= '0;
      scnt_q     <= '0;
      comp_q     <= '0;
      ph_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEADZONE:   dz_q <= cfg_data_i;
          CFG_FULL_SCALE: fs_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (evt_i.valid) begin
            if (!evt_i.link_up) begin
              mx_q <= '0;
              my_q <= '0;
              mz_q <= '0;
              mv_pend_q  <= 1'b0;
              rot_pend_q <= 1'b0;
            end else if (evt_i.kind == KIND_SYNC) begin
              mv_todo_q  <= mv_pend_q;
              rot_todo_q <= rot_pend_q;
              rot_idx_q  <= '0;
              mv_pend_q  <= 1'b0;
              rot_pend_q <= 1'b0;
            end else if (evt_i.kind == KIND_REL) begin
              if (in_dz) begin
                mv_pend_q  <= 1'b1;
                rot_pend_q <= 1'b1;
              end
              dcnt_q <= '0;
            end
          end
        end
        S_DIV:  dcnt_q <= dcnt_q + 1'b1;
        S_APPLY: begin
          case (axis_q)
            AX_X:  begin mx_q <= sat_vec(sum_x); mv_pend_q <= 1'b1; end
            AX_Y:  begin my_q <= sat_vec(dif_y); mv_pend_q <= 1'b1; end
            AX_Z:  begin mz_q <= sat_vec(dif_z); mv_pend_q <= 1'b1; end
            AX_RX: begin rx_q <= s_v; rot_pend_q <= 1'b1; end
            AX_RY: begin ry_q <= s_v; rot_pend_q <= 1'b1; end
            default: begin rz_q <= s_v; rot_pend_q <= 1'b1; end
          endcase
        end
        S_LOAD: begin
          comp_q <= '0;
          ph_q   <= '0;
          if (mv_todo_q) begin
            mv_todo_q <= 1'b0;
            mx_q <= '0;
            my_q <= '0;
            mz_q <= '0;
          end else begin
            rot_idx_q <= rot_idx_q + 1'b1;
            if (rot_idx_q == 2'd2) rot_todo_q <= 1'b0;
          end
        end
        S_MUL: begin
          if (ph_q == 2'd2) begin
            ph_q   <= '0;
            comp_q <= comp_q + 1'b1;
            scnt_q <= '0;
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        S_SQRT: scnt_q <= scnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        axis_q <= evt_i.code[2:0];
        neg_q  <= evt_i.axis_value[RAW_W-1];
        rem_q  <= '0;
        dvs_q  <= fs_q - dz_q;
        if (fs_q > dz_q) num_q <= NW'(lim - dz_q) << FRAC_BITS;
        else num_q <= NW'(1) << FRAC_BITS;
        cx_q   <= '0;
        cy_q   <= '0;
        cz_q   <= '0;
        act_q  <= ACT_BUTTON;
        mag_q  <= MAG_W'(BUTTON_MAG);
        last_q <= 1'b1;
      end
      S_DIV: begin
        rem_q <= dbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        num_q <= {num_q[NW-2:0], dbit};
      end
      S_LOAD: begin
        acc_q <= '0;
        if (mv_todo_q) begin
          cx_q   <= mx_q;
          cy_q   <= my_q;
          cz_q   <= mz_q;
          act_q  <= ACT_MOVE;
          last_q <= !rot_todo_q;
        end else begin
          cx_q   <= (rot_idx_q == 2'd0) ? rx_q : '0;
          cy_q   <= (rot_idx_q == 2'd1) ? ry_q : '0;
          cz_q   <= (rot_idx_q == 2'd2) ? rz_q : '0;
          act_q  <= ACT_ROTATE;
          last_q <= (rot_idx_q == 2'd2);
        end
      end
      S_MUL: begin
        case (ph_q)
          2'd0:    t_q <= prod[T_W-1:0];
          2'd1:    sq_q <= prod;
          default: begin
            acc_q  <= acc_n;
            rad_q  <= acc_n;
            root_q <= '0;
            srem_q <= '0;
          end
        endcase
      end
      S_SQRT: begin
        rad_q  <= {rad_q[ACC_W-3:0], 2'b00};
        root_q <= root_n;
        srem_q <= srem_n;
        mag_q  <= (root_mag > ROOT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : root_mag[MAG_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/sdr_checker.sv @@
// Port-level checks for the six-axis dead-zone reporter, bound to the top.
// Depends on sdr_pkg and the assertion macro header.
`include "six_axis_deadzone_reporter_core_defines.svh"
module sdr_checker
  import sdr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ACT_W-1:0] action,
  input logic [MAG_W-1:0] magnitude,
  input logic             last,
  input vec_t             vec_x
);

  // one item in flight: never ready while a result is shown
  `SDR_ASSERT_ALWAYS(a_excl, !(in_ready && out_valid), "ready while result pending")
  `SDR_ASSERT(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(action) && $stable(vec_x) && $stable(last)), "stalled result changed")
  `SDR_ASSERT(a_button, (out_valid && action == ACT_BUTTON) |-> (last && magnitude == MAG_W'(BUTTON_MAG) && vec_x == '0), "bad button result")
  `SDR_ASSERT(a_act, out_valid |-> (action == ACT_MOVE || action == ACT_ROTATE || action == ACT_BUTTON), "bad action")

endmodule

bind six_axis_deadzone_reporter_core sdr_checker u_sdr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (evt_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .action    (res_o.action),
  .magnitude (res_o.magnitude),
  .last      (res_o.last),
  .vec_x     (res_o.vec_x)
);
